// ----- hw/rtl/obd_pkg.sv -----
// package: shared types, constants and helpers for the orthonormal basis block
package obd_pkg;

  localparam int OUT_W = 32;
  localparam int NUM_OUT = 9;

  typedef struct packed {
    logic br_x;
    logic nx;
    logic ny;
    logic nz;
    logic zero;
  } obd_meta_t;

  function automatic logic [OUT_W-1:0] apply_sign(input logic neg,
                                                  input logic [OUT_W-1:0] mag);
    apply_sign = neg ? (OUT_W'(0) - mag) : mag;
  endfunction

endpackage

// ----- hw/rtl/obd_lane.sv -----
// one pipelined lane: round(n * 2^frac / sqrt(da * db)) one result bit per stage
module obd_lane #(
  parameter int IN_WIDTH = 24,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*IN_WIDTH:0]    num,
  input  logic [2*IN_WIDTH+1:0]  den_a,
  input  logic [2*IN_WIDTH+1:0]  den_b,
  output logic [OUT_FRAC_BITS:0] mag
);
  import obd_pkg::*;

  localparam int NW = 2 * IN_WIDTH + 1;
  localparam int SW = 2 * IN_WIDTH + 2;
  localparam int NH = (NW + 1) / 2;
  localparam int SH = (SW + 1) / 2;
  localparam int RW = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS + 8;
  localparam int ST = OUT_FRAC_BITS + 1;

  logic [NH-1:0]    n_lo;
  logic [NW-NH-1:0] n_hi;
  logic [SH-1:0]    a_lo, b_lo;
  logic [SW-SH-1:0] a_hi, b_hi;

  logic [2*NH-1:0]         n_ll;
  logic [NW-1:0]           n_lh;
  logic [2*(NW-NH)-1:0]    n_hh;
  logic [2*SH-1:0]         d_ll;
  logic [SW-1:0]           d_lh, d_hl;
  logic [2*(SW-SH)-1:0]    d_hh;

  logic [RW-1:0] nsq, den;

  logic signed [RW-1:0] r  [0:ST];
  logic signed [RW-1:0] dt [0:ST];
  logic signed [RW-1:0] dd [0:ST];
  logic [ST-1:0]        q  [0:ST];

  assign n_lo = num[NH-1:0];
  assign n_hi = num[NW-1:NH];
  assign a_lo = den_a[SH-1:0];
  assign a_hi = den_a[SW-1:SH];
  assign b_lo = den_b[SH-1:0];
  assign b_hi = den_b[SW-1:SH];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      n_ll <= n_lo * n_lo;
      n_lh <= NW'(n_lo * n_hi);
      n_hh <= n_hi * n_hi;
      d_ll <= a_lo * b_lo;
      d_lh <= SW'(a_lo * b_hi);
      d_hl <= SW'(a_hi * b_lo);
      d_hh <= a_hi * b_hi;
    end
  end

  // partial product sums
  always_ff @(posedge clk) begin
    if (en) begin
      nsq <= RW'(n_ll) + (RW'(n_lh) << (NH + 1)) + (RW'(n_hh) << (2 * NH));
      den <= RW'(d_ll) + ((RW'(d_lh) + RW'(d_hl)) << SH) + (RW'(d_hh) << (2 * SH));
    end
  end

  // residual start for q = 0
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= $signed(nsq << (2 * OUT_FRAC_BITS + 2)) - $signed(den);
      dt[0] <= -$signed(den);
      dd[0] <= $signed(den);
      q[0]  <= '0;
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_bit
    localparam int K = OUT_FRAC_BITS - i;
    logic signed [RW-1:0] trial;
    assign trial = r[i] - ((dt[i] <<< (K + 2)) + (dd[i] <<< (2 * K + 2)));
    always_ff @(posedge clk) begin
      if (en) begin
        dd[i+1] <= dd[i];
        if (!trial[RW-1]) begin
          r[i+1]  <= trial;
          dt[i+1] <= dt[i] + (dd[i] <<< (K + 1));
          q[i+1]  <= q[i] | (ST'(1) << K);
        end else begin
          r[i+1]  <= r[i];
          dt[i+1] <= dt[i];
          q[i+1]  <= q[i];
        end
      end
    end
  end

  assign mag = q[ST];

endmodule

// ----- hw/rtl/orthonormal_basis_3d.sv -----
// top level: orthonormal basis of one 3d integer vector
//
// input transfers carry vec_x, vec_y, vec_z as signed integers on s_tdata.
// each input transfer yields one output transfer with nine signed fixed point
// components (unit vector, perpendicular vector, cross product) on m_tdata
// and the all-zero input flag on m_tuser; a zero vector gives zero outputs.
// the pipeline has three front stages for magnitudes, squares and sums,
// two for the wide products, one to seed the root, one per result bit in
// each of eight root lanes, and the output register.
// unless the receiver stalls, throughput is one transfer per cycle: the lane
// bit stages are separate registers, so a new vector enters every cycle.
// reset clears all valid bits; payload registers are not reset.
// when the receiver stalls with a result held, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module orthonormal_basis_3d #(
  parameter int IN_WIDTH = 24,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // vec_x, vec_y, vec_z from bit 0 up, zero fill to bytes
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // unit_x/y/z, perp_x/y/z, third_x/y/z from bit 0 up
  output logic [obd_pkg::NUM_OUT*obd_pkg::OUT_W-1:0] m_tdata,
  // zero_input
  output logic [0:0] m_tuser
);
  import obd_pkg::*;

  localparam int IW = IN_WIDTH;
  localparam int FB = OUT_FRAC_BITS;
  localparam int LAT = FB + 4;
  localparam int NL = 8;

  logic en;

  logic          v1;
  logic [IW-1:0] mx1, my1, mz1;
  logic          nx1, ny1, nz1;
  logic [IW-1:0] in_x, in_y, in_z;

  logic            v2;
  logic [2*IW-1:0] xx2, yy2, zz2, xy2, sz2;
  logic [IW-1:0]   mx2, my2, mz2, n4_2;
  obd_meta_t       meta2;

  logic            v3;
  logic [2*IW+1:0] s3;
  logic [2*IW:0]   p3;
  logic [2*IW-1:0] xy3, sz3;
  logic [IW-1:0]   mx3, my3, mz3, n4_3;
  obd_meta_t       meta3;

  logic [2*IW:0]   ln_num [0:NL-1];
  logic [2*IW+1:0] ln_da  [0:NL-1];
  logic [2*IW+1:0] ln_db  [0:NL-1];
  logic [FB:0]     ln_mag [0:NL-1];
  logic [OUT_W-1:0] mg    [0:NL-1];

  logic      vd [0:LAT-1];
  obd_meta_t md [0:LAT-1];
  obd_meta_t mo;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_x = s_tdata[IW-1:0];
  assign in_y = s_tdata[2*IW-1:IW];
  assign in_z = s_tdata[3*IW-1:2*IW];

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1 <= in_x[IW-1];
      ny1 <= in_y[IW-1];
      nz1 <= in_z[IW-1];
      mx1 <= in_x[IW-1] ? (IW'(0) - in_x) : in_x;
      my1 <= in_y[IW-1] ? (IW'(0) - in_y) : in_y;
      mz1 <= in_z[IW-1] ? (IW'(0) - in_z) : in_z;
    end
  end

  // squares and products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx2 <= mx1 * mx1;
      yy2 <= my1 * my1;
      zz2 <= mz1 * mz1;
      xy2 <= mx1 * my1;
      sz2 <= ((mx1 > my1) ? my1 : mx1) * mz1;
      n4_2 <= (mx1 > my1) ? mx1 : my1;
      mx2 <= mx1;
      my2 <= my1;
      mz2 <= mz1;
      meta2.br_x <= mx1 > my1;
      meta2.nx <= nx1;
      meta2.ny <= ny1;
      meta2.nz <= nz1;
      meta2.zero <= (mx1 == '0) && (my1 == '0) && (mz1 == '0);
    end
  end

  // squared lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= (2*IW+2)'(xx2) + (2*IW+2)'(yy2) + (2*IW+2)'(zz2);
      p3 <= meta2.br_x ? ((2*IW+1)'(xx2) + (2*IW+1)'(zz2))
                       : ((2*IW+1)'(yy2) + (2*IW+1)'(zz2));
      xy3 <= xy2;
      sz3 <= sz2;
      mx3 <= mx2;
      my3 <= my2;
      mz3 <= mz2;
      n4_3 <= n4_2;
      meta3 <= meta2;
    end
  end

  always_comb begin
    ln_num[0] = (2*IW+1)'(mx3);  ln_da[0] = s3;             ln_db[0] = (2*IW+2)'(1);
    ln_num[1] = (2*IW+1)'(my3);  ln_da[1] = s3;             ln_db[1] = (2*IW+2)'(1);
    ln_num[2] = (2*IW+1)'(mz3);  ln_da[2] = s3;             ln_db[2] = (2*IW+2)'(1);
    ln_num[3] = (2*IW+1)'(mz3);  ln_da[3] = (2*IW+2)'(p3);  ln_db[3] = (2*IW+2)'(1);
    ln_num[4] = (2*IW+1)'(n4_3); ln_da[4] = (2*IW+2)'(p3);  ln_db[4] = (2*IW+2)'(1);
    ln_num[5] = (2*IW+1)'(xy3);  ln_da[5] = s3;             ln_db[5] = (2*IW+2)'(p3);
    ln_num[6] = p3;              ln_da[6] = s3;             ln_db[6] = (2*IW+2)'(p3);
    ln_num[7] = (2*IW+1)'(sz3);  ln_da[7] = s3;             ln_db[7] = (2*IW+2)'(p3);
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    obd_lane #(
      .IN_WIDTH(IN_WIDTH),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .en(en),
      .num(ln_num[l]),
      .den_a(ln_da[l]),
      .den_b(ln_db[l]),
      .mag(ln_mag[l])
    );
    assign mg[l] = OUT_W'(ln_mag[l]);
  end

  // side data alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v3;
      for (int i = 1; i < LAT; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= meta3;
      for (int i = 1; i < LAT; i++) md[i] <= md[i-1];
    end
  end

  assign mo = md[LAT-1];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= mo.zero;
      if (mo.zero) begin
        m_tdata <= '0;
      end else begin
        m_tdata[0*OUT_W +: OUT_W] <= apply_sign(mo.nx, mg[0]);
        m_tdata[1*OUT_W +: OUT_W] <= apply_sign(mo.ny, mg[1]);
        m_tdata[2*OUT_W +: OUT_W] <= apply_sign(mo.nz, mg[2]);
        if (mo.br_x) begin
          m_tdata[3*OUT_W +: OUT_W] <= apply_sign(!mo.nz, mg[3]);
          m_tdata[4*OUT_W +: OUT_W] <= '0;
          m_tdata[5*OUT_W +: OUT_W] <= apply_sign(mo.nx, mg[4]);
          m_tdata[6*OUT_W +: OUT_W] <= apply_sign(mo.nx ^ mo.ny, mg[5]);
          m_tdata[7*OUT_W +: OUT_W] <= apply_sign(1'b1, mg[6]);
          m_tdata[8*OUT_W +: OUT_W] <= apply_sign(mo.ny ^ mo.nz, mg[7]);
        end else begin
          m_tdata[3*OUT_W +: OUT_W] <= '0;
          m_tdata[4*OUT_W +: OUT_W] <= apply_sign(!mo.nz, mg[3]);
          m_tdata[5*OUT_W +: OUT_W] <= apply_sign(mo.ny, mg[4]);
          m_tdata[6*OUT_W +: OUT_W] <= apply_sign(1'b0, mg[6]);
          m_tdata[7*OUT_W +: OUT_W] <= apply_sign(mo.nx == mo.ny, mg[5]);
          m_tdata[8*OUT_W +: OUT_W] <= apply_sign(mo.nx == mo.nz, mg[7]);
        end
      end
    end
  end

endmodule
